// ===== sv/rcia_pkg.sv =====
`default_nettype none
package rcia_pkg;
  localparam int unsigned IdBits    = 10;
  localparam int unsigned CountBits = 16;
  localparam int unsigned QDepth    = 1 << IdBits;
  localparam logic [IdBits-1:0]    MaxId    = {IdBits{1'b1}};
  localparam logic [CountBits-1:0] MaxCount = {CountBits{1'b1}};

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RETAIN  = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_RENEW   = 3'd3,
    CMD_ASSIGN  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_LIVE  = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD, S_DEC, S_WR2, S_OUT
  } eng_state_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [IdBits-1:0] own_id;
    logic [IdBits-1:0] source_id;
  } item_t;

  typedef struct packed {
    logic [IdBits-1:0]    new_id;
    logic [1:0]           status;
    logic                 freed;
    logic [CountBits-1:0] ref_count;
  } result_t;
endpackage
`default_nettype wire

// ===== sv/rcia_front.sv =====
`default_nettype none
// two-entry command queue between the input port and the engine
module rcia_front import rcia_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  output logic       full_o,
  input  wire item_t item_i,
  output logic       valid_o,
  input  wire logic  take_i,
  output item_t      item_o
);
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rp_q];
  assign wr = push_i && !full_o;
  assign rd = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ===== sv/rcia_engine.sv =====
`default_nettype none
// Count table: own count read on take, source count read in RD, first write
// in DEC, second write in WR2. Zeroed by a clearing pass after reset.
module rcia_engine import rcia_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         take_o,
  input  wire item_t   item_i,
  output logic         res_valid_o,
  input  wire logic    res_ready_i,
  output result_t      res_o
);
  eng_state_e state_q, state_d;
  item_t  it_q;

  logic [CountBits-1:0] cnt_mem [QDepth];
  logic [IdBits-1:0]    fq_mem [QDepth];
  logic [IdBits-1:0]    clr_q;

  logic [CountBits-1:0] own_rd_q, src_rd_q;
  logic [IdBits-1:0]    fq_rd_q;
  logic [IdBits:0]      fresh_q;
  logic [IdBits-1:0]    head_q, tail_q;
  logic [IdBits:0]      fcnt_q;
  result_t              res_q, res_d;

  logic                 w1_en, w2_en, w2_en_q, fq_push, take_id, w2_next;
  logic [IdBits-1:0]    w1_a, w2_a, w2_a_q, nid;
  logic [CountBits-1:0] w1_v, w2_v, w2_v_q;

  logic own_z, own_live, src_live, empty_pool;
  logic [CountBits-1:0] own_c, src_c, own_dec;

  assign own_c = own_rd_q;
  assign src_c = src_rd_q;
  assign own_z = it_q.own_id == '0;
  assign own_live = !own_z && own_c != '0;
  assign src_live = it_q.source_id != '0 && src_c != '0;
  assign empty_pool = fcnt_q == '0 && fresh_q[IdBits];
  assign own_dec = own_c - 1'b1;
  assign nid = (fcnt_q != '0) ? fq_rd_q : fresh_q[IdBits-1:0];

  always_comb begin
    res_d = '0;
    w1_en = 1'b0; w1_a = '0; w1_v = '0;
    w2_en = 1'b0; w2_a = '0; w2_v = '0;
    fq_push = 1'b0; take_id = 1'b0;
    unique case (it_q.cmd)
      CMD_ALLOC: begin
        if (empty_pool) res_d.status = ST_EXHAUSTED;
        else begin
          take_id = 1'b1; res_d.new_id = nid; res_d.ref_count = CountBits'(1);
          w1_en = 1'b1; w1_a = nid; w1_v = CountBits'(1);
        end
      end
      CMD_RETAIN: begin
        res_d.new_id = it_q.source_id;
        if (!src_live) res_d.status = ST_NOT_LIVE;
        else if (src_c == MaxCount) begin
          res_d.status = ST_SATURATED; res_d.ref_count = src_c;
        end else begin
          res_d.ref_count = src_c + 1'b1;
          w1_en = 1'b1; w1_a = it_q.source_id; w1_v = src_c + 1'b1;
        end
      end
      CMD_RELEASE: begin
        res_d.new_id = it_q.own_id;
        if (!own_z) begin
          if (!own_live) res_d.status = ST_NOT_LIVE;
          else begin
            res_d.ref_count = own_dec; res_d.freed = own_dec == '0;
            fq_push = own_dec == '0;
            w1_en = 1'b1; w1_a = it_q.own_id; w1_v = own_dec;
          end
        end
      end
      CMD_RENEW: begin
        if (!own_z && !own_live) res_d.status = ST_NOT_LIVE;
        else if (empty_pool) res_d.status = ST_EXHAUSTED;
        else begin
          take_id = 1'b1; res_d.new_id = nid; res_d.ref_count = CountBits'(1);
          w1_en = 1'b1; w1_a = nid; w1_v = CountBits'(1);
          if (!own_z) begin
            res_d.freed = own_dec == '0; fq_push = own_dec == '0;
            w2_en = 1'b1; w2_a = it_q.own_id; w2_v = own_dec;
          end
        end
      end
      CMD_ASSIGN: begin
        res_d.new_id = it_q.source_id;
        if (!src_live || (!own_z && !own_live)) res_d.status = ST_NOT_LIVE;
        else if (it_q.own_id == it_q.source_id) res_d.ref_count = src_c;
        else if (src_c == MaxCount) begin
          res_d.status = ST_SATURATED; res_d.ref_count = src_c;
        end else begin
          res_d.ref_count = src_c + 1'b1;
          w1_en = 1'b1; w1_a = it_q.source_id; w1_v = src_c + 1'b1;
          if (!own_z) begin
            res_d.freed = own_dec == '0; fq_push = own_dec == '0;
            w2_en = 1'b1; w2_a = it_q.own_id; w2_v = own_dec;
          end
        end
      end
      default: ;
    endcase
  end

  assign w2_next = state_q == S_WR2;
  assign take_o = state_q == S_IDLE && valid_i;
  assign res_valid_o = state_q == S_OUT;
  assign res_o = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == MaxId) state_d = S_IDLE;
      S_IDLE: if (valid_i) state_d = S_RD;
      S_RD:   state_d = S_DEC;
      S_DEC:  state_d = w2_en ? S_WR2 : S_OUT;
      S_WR2:  state_d = S_OUT;
      S_OUT:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // count table: one port, read or write each cycle
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && valid_i) begin
      it_q <= item_i;
      own_rd_q <= cnt_mem[item_i.own_id];
    end
    if (state_q == S_CLR) cnt_mem[clr_q] <= '0;
    if (state_q == S_RD) src_rd_q <= cnt_mem[it_q.source_id];
    if (state_q == S_RD) fq_rd_q <= fq_mem[head_q];
    if (state_q == S_DEC && w1_en) cnt_mem[w1_a] <= w1_v;
    if (w2_next && w2_en_q) cnt_mem[w2_a_q] <= w2_v_q;
    if (state_q == S_DEC && fq_push) fq_mem[tail_q] <= it_q.own_id;
    if (state_q == S_DEC) begin
      res_q <= res_d; w2_a_q <= w2_a; w2_v_q <= w2_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; fresh_q <= (IdBits+1)'(1);
      head_q <= '0; tail_q <= '0; fcnt_q <= '0; w2_en_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (state_q == S_DEC) begin
        w2_en_q <= w2_en;
        if (take_id) begin
          if (fcnt_q != '0) head_q <= head_q + 1'b1;
          else fresh_q <= fresh_q + 1'b1;
        end
        if (fq_push) tail_q <= tail_q + 1'b1;
        fcnt_q <= fcnt_q + {{IdBits{1'b0}}, fq_push}
                  - {{IdBits{1'b0}}, take_id && fcnt_q != '0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/refcounted_id_allocator.sv =====
`default_nettype none
// channel   | dir | handshake   | payload
// command   | in  | push / full | cmd_i, own_id_i, source_id_i
// result    | out | empty / pop | new_id_o, status_o, freed_o, ref_count_o
// After reset the engine zeroes the count table; meanwhile the front takes up to
// two commands and then raises full.
// The single-port count table sets the pace, one command at a time: take, source
// read, decide and write, a second write when renew or assign also drop own_id, result.
// A result waits in its register until popped; the engine stalls meanwhile
// and the two-entry front queue fills.
module refcounted_id_allocator import rcia_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire logic [2:0]   cmd_i,
  input  wire logic [9:0]   own_id_i,
  input  wire logic [9:0]   source_id_i,
  output logic              empty,
  input  wire logic         pop,
  output logic [9:0]        new_id_o,
  output logic [1:0]        status_o,
  output logic              freed_o,
  output logic [15:0]       ref_count_o
);
  item_t   in_item, q_item;
  logic    q_valid, q_take, r_valid;
  result_t res;

  assign in_item = '{cmd: cmd_i, own_id: own_id_i, source_id: source_id_i};

  rcia_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .valid_o(q_valid), .take_i(q_take), .item_o(q_item)
  );

  rcia_engine u_engine (
    .clk_i, .rst_ni, .valid_i(q_valid), .take_o(q_take), .item_i(q_item),
    .res_valid_o(r_valid), .res_ready_i(pop), .res_o(res)
  );

  assign empty = !r_valid;
  assign new_id_o = res.new_id;
  assign status_o = res.status;
  assign freed_o = res.freed;
  assign ref_count_o = res.ref_count;

  a_exh_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o == ST_EXHAUSTED |-> new_id_o == '0 && ref_count_o == '0)
    else $error("exhausted result not zero");
  a_freed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && freed_o |-> status_o == ST_OK)
    else $error("freed with error status");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> q_valid)
    else $error("engine took from empty queue");
endmodule
`default_nettype wire

// ===== dv/refcounted_id_allocator_tb.sv =====
`default_nettype none
module refcounted_id_allocator_tb;
  import rcia_pkg::*;

  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam int unsigned IdlePct = 27;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [2:0] cmd_i = '0;
  logic [9:0] own_id_i = '0;
  logic [9:0] source_id_i = '0;
  logic       full, empty, freed_o;
  logic [9:0] new_id_o;
  logic [1:0] status_o;
  logic [15:0] ref_count_o;

  refcounted_id_allocator u_dut (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .own_id_i, .source_id_i,
    .empty, .pop, .new_id_o, .status_o, .freed_o, .ref_count_o
  );

  // predictor state
  logic [CountBits-1:0] refs[QDepth];
  logic [IdBits-1:0]    free_ids[QDepth];
  logic [IdBits-1:0]    fq_head, fq_tail;
  logic [IdBits:0]      fq_count, fresh_id;

  // expected results in transaction order
  result_t     exp_ring[64];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  bit      steady = 1'b0;
  int      mismatches = 0;
  int      sent = 0;
  int      checked = 0;
  int      status_seen[4];

  function automatic bit is_live(logic [IdBits-1:0] id);
    return id != '0 && refs[id] != '0;
  endfunction

  function automatic bit pool_dry();
    return fq_count == '0 && fresh_id > MaxId;
  endfunction

  function automatic logic [IdBits-1:0] take_id();
    logic [IdBits-1:0] id;
    if (fq_count != '0) begin
      id = free_ids[fq_head];
      fq_head++;
      fq_count--;
    end else begin
      id = fresh_id[IdBits-1:0];
      fresh_id++;
    end
    refs[id] = 16'd1;
    return id;
  endfunction

  function automatic logic drop_ref(logic [IdBits-1:0] id);
    refs[id]--;
    if (refs[id] == '0) begin
      free_ids[fq_tail] = id;
      fq_tail++;
      fq_count++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t allocator_step(logic [2:0] c, logic [9:0] own,
                                             logic [9:0] src);
    result_t r;
    r = '0;
    case (c)
      CMD_ALLOC: begin
        if (pool_dry()) r.status = ST_EXHAUSTED;
        else begin
          r.new_id = take_id();
          r.ref_count = 16'd1;
        end
      end
      CMD_RETAIN: begin
        r.new_id = src;
        if (!is_live(src)) r.status = ST_NOT_LIVE;
        else if (refs[src] == MaxCount) begin
          r.status = ST_SATURATED;
          r.ref_count = refs[src];
        end else begin
          refs[src]++;
          r.ref_count = refs[src];
        end
      end
      CMD_RELEASE: begin
        r.new_id = own;
        if (own != '0) begin
          if (!is_live(own)) r.status = ST_NOT_LIVE;
          else begin
            r.freed = drop_ref(own);
            r.ref_count = refs[own];
          end
        end
      end
      CMD_RENEW: begin
        if (own != '0 && !is_live(own)) r.status = ST_NOT_LIVE;
        else if (pool_dry()) r.status = ST_EXHAUSTED;
        else begin
          r.new_id = take_id();
          if (own != '0) r.freed = drop_ref(own);
          r.ref_count = 16'd1;
        end
      end
      CMD_ASSIGN: begin
        r.new_id = src;
        if (!is_live(src) || (own != '0 && !is_live(own))) r.status = ST_NOT_LIVE;
        else if (own == src) r.ref_count = refs[src];
        else if (refs[src] == MaxCount) begin
          r.status = ST_SATURATED;
          r.ref_count = refs[src];
        end else begin
          if (own != '0) r.freed = drop_ref(own);
          refs[src]++;
          r.ref_count = refs[src];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("FAIL refcounted_id_allocator");
    $finish;
  end

  // accepted transactions feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      exp_ring[6'(exp_wr)] = allocator_step(cmd_i, own_id_i, source_id_i);
      exp_wr++;
      sent++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && pop && !empty) begin
      checked++;
      status_seen[status_o]++;
      if (exp_rd == exp_wr) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result new_id=%0d", new_id_o);
      end else begin
        exp_r = exp_ring[6'(exp_rd)];
        exp_rd++;
        if (new_id_o !== exp_r.new_id || status_o !== exp_r.status ||
            freed_o !== exp_r.freed || ref_count_o !== exp_r.ref_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result %0d exp id=%0d st=%0d fr=%0d cnt=%0d",
                      " got id=%0d st=%0d fr=%0d cnt=%0d"},
                     checked, exp_r.new_id, exp_r.status, exp_r.freed, exp_r.ref_count,
                     new_id_o, status_o, freed_o, ref_count_o);
        end
      end
    end
  end

  task automatic send(logic [2:0] c, logic [9:0] own, logic [9:0] src);
    while (!steady && $urandom_range(99) < IdlePct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= c;
    own_id_i <= own;
    source_id_i <= src;
    do @(posedge clk_i); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (exp_rd != exp_wr) @(posedge clk_i);
  endtask

  function automatic logic [9:0] pick_id();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10) return '0;
    if (p < 20) return 10'($urandom);
    return 10'($urandom_range(1, MaxId));
  endfunction

  task automatic test_directed();
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) send(3'(c), 10'h3FF, 10'h3FF);
    send(CMD_RELEASE, '0, '0);
    send(CMD_RELEASE, 10'd5, '0);
    send(CMD_RETAIN, '0, '0);
    send(CMD_RETAIN, '0, MaxId);
    send(CMD_ALLOC, '0, '0);
    send(CMD_RETAIN, '0, 10'd1);
    send(CMD_ASSIGN, 10'd1, 10'd1);
    send(CMD_RENEW, '0, '0);
    send(CMD_RENEW, 10'd1, '0);
    send(CMD_RELEASE, 10'd1, '0);
    send(CMD_RENEW, MaxId, '0);
    send(CMD_ASSIGN, '0, 10'd2);
    send(CMD_ASSIGN, MaxId, 10'd2);
    send(CMD_ASSIGN, 10'd2, 10'd3);
    send(CMD_ASSIGN, 10'd3, 10'd2);
    send(CMD_ALLOC, MaxId, MaxId);
    send(CMD_RELEASE, 10'd2, '0);
    drain();
  endtask

  task automatic test_exhaustion();
    steady = 1'b1;
    for (int i = 0; i < QDepth + 2; i++) send(CMD_ALLOC, '0, '0);
    steady = 1'b0;
    send(CMD_RENEW, '0, '0);
    send(CMD_RENEW, 10'd4, '0);
    drain();
    // free some ids so random traffic sees both live and dead ids
    for (int i = 0; i < 64; i++) send(CMD_RELEASE, 10'($urandom_range(1, MaxId)), '0);
    drain();
  endtask

  task automatic test_random();
    for (int i = 0; i < 96; i++) begin
      if (i % 32 == 16) drain();
      send(3'($urandom_range(0, CMD_UNUSED_LO)), pick_id(), pick_id());
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < QDepth; i++) refs[i] = '0;
    fq_head = '0;
    fq_tail = '0;
    fq_count = '0;
    fresh_id = 11'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_exhaustion();
    test_random();
    repeat (40) @(posedge clk_i);
    if (exp_rd != exp_wr) begin
      mismatches++;
      $display("ERROR: %0d results never arrived", exp_wr - exp_rd);
    end
    $display("Covered %0d commands: directed corners, pool exhaustion, random mix.",
             sent);
    $display("Status counts ok=%0d exhausted=%0d not_live=%0d saturated=%0d, mismatches=%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatches);
    if (mismatches == 0) begin
      $display("PASS refcounted_id_allocator");
    end else begin
      $display("FAIL refcounted_id_allocator");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/rcia_pkg.sv
sv/rcia_front.sv
sv/rcia_engine.sv
sv/refcounted_id_allocator.sv
dv/refcounted_id_allocator_tb.sv
